[hdl/bhm_pkg.sv]
// ----------------------------------------------------------------------------
// bhm_pkg
// Shared types and defaults for the byte histogram mode finder.
// ----------------------------------------------------------------------------
package bhm_pkg;

  // Default sizing of the counter memory
  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int COUNT_WIDTH_DEF   = 16;

  // Fixed field widths of the beats
  localparam int CHAR_W  = 8;
  localparam int OCC_W   = 16;

  // One input beat as it moves down the pipe
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              has_char;
    logic              end_of_string;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [CHAR_W-1:0] most_common_char;
    logic [OCC_W-1:0]  occurrence_count;
  } result_t;

endpackage

[hdl/bhm_ram.sv]
// ----------------------------------------------------------------------------
// bhm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bhm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; returns old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/bhm_tally.sv]
// ----------------------------------------------------------------------------
// bhm_tally
// Read-modify-write stage of the counter memory: applies touched flags and
// forwarding to the read data, bumps the count, tracks the leading byte and
// forms the result on the end of a string.
// ----------------------------------------------------------------------------
module bhm_tally import bhm_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s1_valid,
  input  item_t                            s1_item,
  input  logic [COUNT_WIDTH-1:0]           rd_data,
  output logic                             wr_en,
  output logic [$clog2(ALPHABET_SIZE)-1:0] wr_addr,
  output logic [COUNT_WIDTH-1:0]           wr_data,
  output logic                             push,
  output result_t                          result
);

  localparam int AW = $clog2(ALPHABET_SIZE);

  logic [ALPHABET_SIZE-1:0] touched;
  logic                     fwd_valid;
  logic [AW-1:0]            fwd_idx;
  logic [COUNT_WIDTH-1:0]   fwd_data;
  logic [CHAR_W-1:0]        best_char;
  logic [COUNT_WIDTH-1:0]   best_count;

  logic                     in_range;
  logic [AW-1:0]            idx;
  logic                     cnt_en;
  logic                     fwd_hit;
  logic [COUNT_WIDTH-1:0]   old_count;
  logic [COUNT_WIDTH-1:0]   new_count;
  logic                     better;
  logic                     take;
  logic                     at_end;
  logic [CHAR_W-1:0]        res_char;
  logic [COUNT_WIDTH-1:0]   res_count;

  // Decode the beat; bytes beyond the alphabet are not counted
  assign in_range = {1'b0, s1_item.char_code} < (CHAR_W + 1)'(ALPHABET_SIZE);
  assign idx      = s1_item.char_code[AW-1:0];
  assign cnt_en   = s1_valid & s1_item.has_char & in_range;
  assign at_end   = s1_valid & s1_item.end_of_string;

  // Take the last write when it hit the same entry; untouched entries read zero
  assign fwd_hit   = fwd_valid & (fwd_idx == idx);
  assign old_count = touched[idx] ? (fwd_hit ? fwd_data : rd_data) : '0;
  assign new_count = (old_count == {COUNT_WIDTH{1'b1}}) ? old_count
                                                        : old_count + COUNT_WIDTH'(1);

  // Lead changes on a higher count, or an equal count at a lower byte
  assign better = (new_count > best_count) ||
                  ((new_count == best_count) && (s1_item.char_code < best_char));
  assign take   = cnt_en & better;

  assign res_char  = take ? s1_item.char_code : best_char;
  assign res_count = take ? new_count : best_count;

  // Write back the bumped count
  assign wr_en   = cnt_en;
  assign wr_addr = idx;
  assign wr_data = new_count;

  // Touched flags: set on a count, drop all at the end of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      touched <= '0;
    end else if (at_end) begin
      touched <= '0;
    end else if (cnt_en) begin
      touched[idx] <= 1'b1;
    end
  end

  // Hold the last write into the next cycle to cover the read that overlapped it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= cnt_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_en) begin
      fwd_idx  <= idx;
      fwd_data <= new_count;
    end
  end

  // Leader registers
  always_ff @(posedge clk) begin
    if (rst) begin
      best_char  <= '0;
      best_count <= '0;
    end else if (at_end) begin
      best_char  <= '0;
      best_count <= '0;
    end else if (take) begin
      best_char  <= s1_item.char_code;
      best_count <= new_count;
    end
  end

  // Result beat; clamp or zero-extend the count to the output width
  assign push                    = at_end;
  assign result.most_common_char = res_char;

  generate
    if (COUNT_WIDTH > OCC_W) begin : g_clamp
      assign result.occurrence_count = (|res_count[COUNT_WIDTH-1:OCC_W]) ? {OCC_W{1'b1}}
                                                                         : res_count[OCC_W-1:0];
    end else begin : g_extend
      assign result.occurrence_count = OCC_W'(res_count);
    end
  endgenerate

endmodule

[hdl/bhm_out_fifo.sv]
// ----------------------------------------------------------------------------
// bhm_out_fifo
// Two-entry result queue that decouples the tally stage from the output
// stall, and tells the input side whether one more result still fits.
// ----------------------------------------------------------------------------
module bhm_out_fifo import bhm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_data,
  output logic    room
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  result_t    e0;
  result_t    e1;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign out_data  = e0;
  assign pop       = out_valid & ~out_stall;

  // Occupancy after this edge; a new beat accepted now may push next cycle
  always_comb begin
    cnt_next = cnt;
    if (push & ~pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop & ~push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  assign room = (cnt_next <= 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Shift entries toward the head
  always_ff @(posedge clk) begin
    if (push & pop) begin
      if (cnt == 2'd2) begin
        e0 <= e1;
        e1 <= push_data;
      end else begin
        e0 <= push_data;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= push_data;
      end else begin
        e1 <= push_data;
      end
    end
  end

endmodule

[hdl/byte_histogram_mode.sv]
// ----------------------------------------------------------------------------
// byte_histogram_mode
// Most frequent byte of a string, from a per-byte counter memory.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the input is not stalled. Each accepted
// beat reads its counter from a RAM with a registered read port, and in
// the next cycle the count is bumped and written back and the leading byte
// is updated; a repeat of the same byte in the following beat is forwarded
// from the write, so the rate holds at one beat per clock. The result of a
// string passes the stage register and the result queue before it appears.
// Counters are cleared at the end of a string at once through per-entry
// touched flags, so there is no clearing pass after reset. Results wait in
// a two-entry queue; the input stalls only while it is about to fill up.
// ----------------------------------------------------------------------------
module byte_histogram_mode import bhm_pkg::*; #(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              has_char,
  input  logic              end_of_string,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [CHAR_W-1:0] most_common_char,
  output logic [OCC_W-1:0]  occurrence_count
);

  localparam int AW = $clog2(ALPHABET_SIZE);

  logic                   accept;
  logic                   s1_valid;
  item_t                  s1_item;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   push;
  result_t                result;
  result_t                out_data;
  logic                   room;

  assign item_stall = ~room;
  assign accept     = item_valid & ~item_stall;

  // Stage register alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.char_code     <= char_code;
      s1_item.has_char      <= has_char;
      s1_item.end_of_string <= end_of_string;
    end
  end

  // Counter memory
  bhm_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (ALPHABET_SIZE)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (char_code[AW-1:0]),
    .rd_data (rd_data)
  );

  // Count update and leader tracking
  bhm_tally #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_tally (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .result   (result)
  );

  // Result queue
  bhm_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .out_stall (result_stall),
    .out_valid (result_valid),
    .out_data  (out_data),
    .room      (room)
  );

  assign most_common_char = out_data.most_common_char;
  assign occurrence_count = out_data.occurrence_count;

endmodule

[hdl/bhm_check.sv]
// ----------------------------------------------------------------------------
// bhm_check
// Port-level checks for byte_histogram_mode, bound to the top level.
// ----------------------------------------------------------------------------
module bhm_check import bhm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic [CHAR_W-1:0] char_code,
  input logic              has_char,
  input logic              end_of_string,
  input logic              result_valid,
  input logic              result_stall,
  input logic [CHAR_W-1:0] most_common_char,
  input logic [OCC_W-1:0]  occurrence_count
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat shown right after reset");

  // A stalled result beat stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // The input only stalls while results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with no result queued");

  // A zero count only comes from an empty string, which reports byte zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && (occurrence_count == '0) |-> (most_common_char == '0))
    else $error("zero count reported with a nonzero byte");

  // A stalled input beat stays up with the same payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=>
      item_valid && $stable({char_code, has_char, end_of_string}))
    else $error("input beat changed while stalled");

endmodule

bind byte_histogram_mode bhm_check u_check (.*);

[sim/tb_byte_histogram_mode.sv]
// ----------------------------------------------------------------------------
// tb_byte_histogram_mode
// Self-checking bench for the most-frequent-byte finder.
// ----------------------------------------------------------------------------
// Strings of bytes are queued by a stimulus block and sent by a clocked
// driver. Each accepted beat updates a local byte tally, and that tally
// predicts the result of each string. A clocked monitor checks every result
// beat against the oldest prediction. The run has three traffic phases:
// light sender gaps with heavy receiver stalls, the reverse, and none. It
// also has one long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_byte_histogram_mode;
  import bhm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TALLY_DEPTH = ALPHABET_SIZE_DEF;
  localparam int TALLY_W     = COUNT_WIDTH_DEF;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
  localparam int PHASE_BEATS = 230;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic [CHAR_W-1:0] char_code = '0;
  logic              has_char = 1'b0;
  logic              end_of_string = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [CHAR_W-1:0] most_common_char;
  logic [OCC_W-1:0]  occurrence_count;

  // Beats waiting to be sent and results waiting to arrive
  item_t   byte_queue[$];
  result_t mode_queue[$];

  // Local copy of the tally state
  logic [TALLY_W-1:0] tally [TALLY_DEPTH];
  bit                 tally_seen [TALLY_DEPTH];
  logic [CHAR_W-1:0]  lead_char = '0;
  logic [TALLY_W-1:0] lead_count = '0;

  int send_idle_pct = 16;
  int recv_idle_pct = 70;
  int beats_queued = 0;
  int beats_taken = 0;
  int error_count = 0;

  byte_histogram_mode dut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .char_code        (char_code),
    .has_char         (has_char),
    .end_of_string    (end_of_string),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .most_common_char (most_common_char),
    .occurrence_count (occurrence_count)
  );

  // Clock and reset
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Count one accepted beat; on the end mark, queue the mode and clear
  task automatic tally_beat(input logic [CHAR_W-1:0] code, input logic counted,
                            input logic last);
    logic [TALLY_W-1:0] prior;
    logic [TALLY_W-1:0] bumped;
    result_t res;
    if (counted && int'(code) < TALLY_DEPTH) begin
      prior = tally_seen[code] ? tally[code] : '0;
      bumped = (prior == TALLY_MAX) ? TALLY_MAX : prior + 1'b1;
      tally[code] = bumped;
      tally_seen[code] = 1'b1;
      if (bumped > lead_count || (bumped == lead_count && code < lead_char)) begin
        lead_count = bumped;
        lead_char = code;
      end
    end
    if (last) begin
      res.most_common_char = lead_char;
      res.occurrence_count = (TALLY_W > OCC_W && lead_count > {OCC_W{1'b1}}) ?
                             {OCC_W{1'b1}} : OCC_W'(lead_count);
      mode_queue.push_back(res);
      foreach (tally_seen[i]) tally_seen[i] = 1'b0;
      lead_char = '0;
      lead_count = '0;
    end
  endtask

  // Drive input beats; advance only on acceptance
  always @(posedge clk) begin
    item_t beat;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        tally_beat(char_code, has_char, end_of_string);
        beats_taken <= beats_taken + 1;
      end
      if (!item_valid || !item_stall) begin
        if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          beat = byte_queue.pop_front();
          char_code <= beat.char_code;
          has_char <= beat.has_char;
          end_of_string <= beat.end_of_string;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Drive result stall: random, plus one long hold to back the block up
  always @(posedge clk) begin
    static int hold_left = 0;
    static bit hold_done = 1'b0;
    if (!rst && !hold_done && beats_taken >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (mode_queue.size() == 0) begin
        $display("%0t: result with none expected: char %h count %0d",
                 $time, most_common_char, occurrence_count);
        error_count = error_count + 1;
      end else begin
        want = mode_queue.pop_front();
        if (most_common_char !== want.most_common_char) begin
          $display("%0t: most_common_char expected %h actual %h",
                   $time, want.most_common_char, most_common_char);
          error_count = error_count + 1;
        end
        if (occurrence_count !== want.occurrence_count) begin
          $display("%0t: occurrence_count expected %0d actual %0d",
                   $time, want.occurrence_count, occurrence_count);
          error_count = error_count + 1;
        end
      end
    end
  end

  task automatic add_beat(input logic [CHAR_W-1:0] code, input logic counted,
                          input logic last);
    item_t beat;
    beat.char_code = code;
    beat.has_char = counted;
    beat.end_of_string = last;
    byte_queue.push_back(beat);
    beats_queued++;
  endtask

  // One random string; narrow byte spans give repeats and ties
  task automatic add_random_string();
    int len;
    int span;
    int base;
    logic [CHAR_W-1:0] code;
    logic counted;
    len = $urandom_range(0, 12);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
    span = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 6);
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_beat(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      add_beat(CHAR_W'((base + $urandom_range(0, span - 1)) % 256), 1'b1, 1'b0);
    end
    counted = 1'($urandom_range(0, 1));
    code = counted ? CHAR_W'((base + $urandom_range(0, span - 1)) % 256)
                   : CHAR_W'($urandom_range(0, 255));
    add_beat(code, counted, 1'b1);
  endtask

  task automatic drain_sends();
    while (byte_queue.size() != 0 || item_valid) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    int target;
    // Empty string, lone extremes, no-op beat inside a string
    add_beat(8'h3C, 1'b0, 1'b1);
    add_beat(8'hFF, 1'b1, 1'b1);
    add_beat(8'h00, 1'b1, 1'b1);
    add_beat(8'hAA, 1'b1, 1'b0);
    add_beat(8'h11, 1'b0, 1'b0);
    add_beat(8'h55, 1'b1, 1'b1);
    // Ties go to the lower byte when it arrives after the higher one
    add_beat(8'h80, 1'b1, 1'b0);
    add_beat(8'h01, 1'b1, 1'b1);
    add_beat(8'h05, 1'b1, 1'b0);
    add_beat(8'h03, 1'b1, 1'b0);
    add_beat(8'h05, 1'b1, 1'b0);
    add_beat(8'h03, 1'b1, 1'b1);
    // Back-to-back repeats, then an end beat without a byte
    add_beat(8'h42, 1'b1, 1'b0);
    add_beat(8'h42, 1'b1, 1'b0);
    add_beat(8'h42, 1'b1, 1'b1);
    add_beat(8'h07, 1'b1, 1'b0);
    add_beat(8'h09, 1'b1, 1'b0);
    add_beat(8'h07, 1'b1, 1'b0);
    add_beat(8'hFE, 1'b0, 1'b1);
    // Counts left from the last string must not carry over
    add_beat(8'h09, 1'b1, 1'b1);

    target = beats_queued + PHASE_BEATS;
    while (beats_queued < target) add_random_string();
    drain_sends();

    send_idle_pct = 70;
    recv_idle_pct = 16;
    target = beats_queued + PHASE_BEATS;
    while (beats_queued < target) add_random_string();
    drain_sends();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    target = beats_queued + PHASE_BEATS;
    while (beats_queued < target) add_random_string();
    drain_sends();

    while (mode_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
